FILE: rtl/hce_pkg.sv
// ============================================================================
// hce_pkg: shared types and constants for the harmonic confinement energy block
// Field widths, register map, datapath operation codes, controller/datapath
// command and status structs, and the per-mode square-term schedule.
// ============================================================================
package hce_pkg;

    // Payload field widths
    localparam int POS_W    = 20;
    localparam int KIND_W   = 6;
    localparam int MODE_W   = 2;
    localparam int POINT_W  = 60;
    localparam int RAD_W    = 19;
    localparam int K_W      = 32;
    localparam int HW_W     = 2;
    localparam int MASK_W   = 64;
    localparam int ENERGY_W = 64;
    localparam int INF_W    = 2;

    localparam int KIND_COUNT_DEF = 64;

    // APB register map: 64-bit registers at byte address 8*index
    localparam int REG_IDX_LSB = 3;
    localparam int REG_IDX_W   = 3;
    localparam int APB_AW      = REG_IDX_LSB + REG_IDX_W;
    localparam int APB_DW      = 64;

    typedef logic [REG_IDX_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_MODE      = 3'd0;
    localparam t_reg_idx REG_POINT_A   = 3'd1;
    localparam t_reg_idx REG_POINT_B   = 3'd2;
    localparam t_reg_idx REG_RADIUS    = 3'd3;
    localparam t_reg_idx REG_SPRING_K  = 3'd4;
    localparam t_reg_idx REG_HARD_WALL = 3'd5;
    localparam t_reg_idx REG_KIND_MASK = 3'd6;

    // Geometry modes
    localparam logic [MODE_W-1:0] MODE_SPHERE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CYL    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOX    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    // Hard wall codes
    localparam logic [HW_W-1:0] WALL_FINITE  = 2'd0;
    localparam logic [HW_W-1:0] WALL_POS_INF = 2'd1;
    localparam logic [HW_W-1:0] WALL_NEG_INF = 2'd2;

    // Shared multiplier and accumulator widths
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 22;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int U_W        = 45;   // signed squared excess, |u| < 2^43
    localparam int LO_W       = 22;   // low slice of u for the spring product
    localparam int HI_W       = 21;   // high slice of u
    localparam int HI_SHIFT   = 5;    // 2^22 / 2^17
    localparam int FRAC_SHIFT = 17;   // Q.32 to Q.16 and the factor 1/2
    localparam int E_W        = PROD_W + HI_SHIFT;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
    localparam logic [ENERGY_W-1:0] ENERGY_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

    // Datapath operations on the shared multiplier
    typedef logic [3:0] t_op;
    localparam t_op OP_A0 = 4'd0;  // (a.x - p.x)^2
    localparam t_op OP_A1 = 4'd1;
    localparam t_op OP_A2 = 4'd2;
    localparam t_op OP_B0 = 4'd3;  // (p.x - b.x)^2, box only
    localparam t_op OP_B1 = 4'd4;
    localparam t_op OP_B2 = 4'd5;
    localparam t_op OP_R  = 4'd6;  // radius^2, subtracted
    localparam t_op OP_HI = 4'd7;  // |k| * u[42:22]
    localparam t_op OP_LO = 4'd8;  // |k| * u[21:0]

    typedef logic [2:0] t_step;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [POINT_W-1:0] point_a;
        logic [POINT_W-1:0] point_b;
        logic [RAD_W-1:0]   radius;
        logic [K_W-1:0]     wall_k;
        logic [HW_W-1:0]    hard_wall;
        logic [MASK_W-1:0]  kind_mask;
    } t_cfg;

    typedef struct packed {
        logic load;      // latch the incoming particle
        logic op_valid;  // issue op to the multiplier
        t_op  op;
        logic set_inf;   // record the hard wall sign
        logic add_e;     // saturating add of the particle energy
        logic emit;      // load output register, clear group state
    } t_dp_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic sel;       // particle kind confined and mode active
        logic u_pos;     // squared excess above zero
        logic inf_wall;  // spring constant is infinite
        logic last;      // particle closes its group
        logic out_free;  // output register can take a result
    } t_dp_sts;

    // Square term issued at a given step for a geometry
    function automatic t_op sq_op(input logic [MODE_W-1:0] mode, input t_step step);
        t_op op;
        op = OP_R;
        case (mode)
            MODE_BOX: begin
                case (step)
                    3'd0:    op = OP_A0;
                    3'd1:    op = OP_B0;
                    3'd2:    op = OP_A1;
                    3'd3:    op = OP_B1;
                    3'd4:    op = OP_A2;
                    default: op = OP_B2;
                endcase
            end
            MODE_CYL: begin
                case (step)
                    3'd0:    op = OP_A0;
                    3'd1:    op = OP_A1;
                    default: op = OP_R;
                endcase
            end
            default: begin
                case (step)
                    3'd0:    op = OP_A0;
                    3'd1:    op = OP_A1;
                    3'd2:    op = OP_A2;
                    default: op = OP_R;
                endcase
            end
        endcase
        return op;
    endfunction

    // Final step of the square schedule
    function automatic t_step sq_last(input logic [MODE_W-1:0] mode);
        t_step s;
        case (mode)
            MODE_BOX: s = 3'd5;
            MODE_CYL: s = 3'd2;
            default:  s = 3'd3;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/hce_if.sv
// ============================================================================
// hce_if: valid/ready channel interfaces
// Particle input channel and group result channel.
// ============================================================================
interface hce_in_if;
    import hce_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic [KIND_W-1:0]        molecule_kind;
    logic                     last_in_group;

    modport source (output valid, pos_x, pos_y, pos_z, molecule_kind, last_in_group,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, molecule_kind, last_in_group,
                    output ready);
endinterface

interface hce_out_if;
    import hce_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [ENERGY_W-1:0] group_energy;
    logic [INF_W-1:0]           infinite_sign;
    logic                       overflowed;

    modport source (output valid, group_energy, infinite_sign, overflowed, input ready);
    modport sink   (input valid, group_energy, infinite_sign, overflowed, output ready);
endinterface

FILE: rtl/hce_regs.sv
// ============================================================================
// hce_regs: APB configuration registers
// Seven 64-bit-spaced registers; writes complete in the access phase,
// reads return the stored value zero-extended.
// ============================================================================
module hce_regs #(
    parameter int KIND_COUNT = hce_pkg::KIND_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hce_pkg::APB_AW-1:0] paddr,
    input  logic [hce_pkg::APB_DW-1:0] pwdata,
    output logic [hce_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output hce_pkg::t_cfg              o_cfg
);
    import hce_pkg::*;

    logic [MODE_W-1:0]     r_mode;
    logic [POINT_W-1:0]    r_point_a;
    logic [POINT_W-1:0]    r_point_b;
    logic [RAD_W-1:0]      r_radius;
    logic [K_W-1:0]        r_spring_k;
    logic [HW_W-1:0]       r_hard_wall;
    logic [KIND_COUNT-1:0] r_kind_mask;   // kinds at or above KIND_COUNT never confined

    t_reg_idx idx;
    logic     wr;

    assign idx   = paddr[APB_AW-1:REG_IDX_LSB];
    assign wr    = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= '0;
            r_point_a   <= '0;
            r_point_b   <= '0;
            r_radius    <= '0;
            r_spring_k  <= '0;
            r_hard_wall <= '0;
            r_kind_mask <= '0;
        end else if (wr) begin
            case (idx)
                REG_MODE:      r_mode      <= pwdata[MODE_W-1:0];
                REG_POINT_A:   r_point_a   <= pwdata[POINT_W-1:0];
                REG_POINT_B:   r_point_b   <= pwdata[POINT_W-1:0];
                REG_RADIUS:    r_radius    <= pwdata[RAD_W-1:0];
                REG_SPRING_K:  r_spring_k  <= pwdata[K_W-1:0];
                REG_HARD_WALL: r_hard_wall <= pwdata[HW_W-1:0];
                REG_KIND_MASK: r_kind_mask <= pwdata[KIND_COUNT-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (idx)
            REG_MODE:      prdata = APB_DW'(r_mode);
            REG_POINT_A:   prdata = APB_DW'(r_point_a);
            REG_POINT_B:   prdata = APB_DW'(r_point_b);
            REG_RADIUS:    prdata = APB_DW'(r_radius);
            REG_SPRING_K:  prdata = APB_DW'(r_spring_k);
            REG_HARD_WALL: prdata = APB_DW'(r_hard_wall);
            REG_KIND_MASK: prdata = APB_DW'(r_kind_mask);
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.mode      = r_mode;
        o_cfg.point_a   = r_point_a;
        o_cfg.point_b   = r_point_b;
        o_cfg.radius    = r_radius;
        o_cfg.wall_k    = r_spring_k;
        o_cfg.hard_wall = r_hard_wall;
        o_cfg.kind_mask = MASK_W'(r_kind_mask);
    end

endmodule

FILE: rtl/hce_ctrl.sv
// ============================================================================
// hce_ctrl: particle sequencer
// Steps each particle through the square terms, the spring product and the
// group accumulate, then hands the group result to the output register.
// ============================================================================
module hce_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output hce_pkg::t_dp_cmd o_cmd,
    input  hce_pkg::t_dp_sts i_sts
);
    import hce_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_SQ     = 4'd2;
    localparam logic [3:0] S_WAIT   = 4'd3;
    localparam logic [3:0] S_DECIDE = 4'd4;
    localparam logic [3:0] S_LO     = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_ADD    = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0] r_state, n_state;
    t_step      r_step,  n_step;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_step  = '0;
                n_state = i_sts.sel ? S_SQ : S_FIN;
            end
            S_SQ: begin
                o_cmd.op_valid = 1'b1;
                o_cmd.op       = sq_op(i_sts.mode, r_step);
                if (r_step >= sq_last(i_sts.mode)) begin
                    n_state = S_WAIT;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            // last square term lands in the accumulator
            S_WAIT: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (!i_sts.u_pos) begin
                    n_state = S_FIN;
                end else if (i_sts.inf_wall) begin
                    o_cmd.set_inf = 1'b1;
                    n_state       = S_FIN;
                end else begin
                    o_cmd.op_valid = 1'b1;
                    o_cmd.op       = OP_HI;
                    n_state        = S_LO;
                end
            end
            S_LO: begin
                o_cmd.op_valid = 1'b1;
                o_cmd.op       = OP_LO;
                n_state        = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.add_e = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.last) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // A result is only pushed when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("result emitted into a full output register");

    // Every accepted particle goes to the selection check next
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CHECK))
        else $error("accepted particle skipped the selection check");

    // The spring energy is only added after both partial products drained
    a_add_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.add_e |-> ($past(r_state) == S_DRAIN))
        else $error("energy added before the spring product completed");

endmodule

FILE: rtl/hce_dp.sv
// ============================================================================
// hce_dp: confinement energy datapath
// Particle latch, one shared 32x22 multiplier with product register,
// squared-excess and spring-energy accumulators, saturating group sum and
// the result output register.
// ============================================================================
module hce_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hce_pkg::t_cfg                     i_cfg,
    input  hce_pkg::t_dp_cmd                  i_cmd,
    output hce_pkg::t_dp_sts                  o_sts,
    input  logic signed [hce_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [hce_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [hce_pkg::POS_W-1:0]  i_pos_z,
    input  logic [hce_pkg::KIND_W-1:0]        i_molecule_kind,
    input  logic                              i_last_in_group,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [hce_pkg::ENERGY_W-1:0] o_group_energy,
    output logic [hce_pkg::INF_W-1:0]         o_infinite_sign,
    output logic                              o_overflowed
);
    import hce_pkg::*;

    localparam logic [PROD_W:0] RND_HALF = (PROD_W+1)'(1) << (FRAC_SHIFT - 1);

    // Latched particle
    logic signed [POS_W-1:0] r_px, r_py, r_pz;
    logic [KIND_W-1:0]       r_kind;
    logic                    r_last;

    // Multiplier pipeline and accumulators
    logic [PROD_W-1:0]       r_prod;
    t_op                     r_tag;
    logic                    r_tag_vld;
    logic signed [U_W-1:0]   r_u;
    logic [E_W-1:0]          r_e;

    // Group state
    logic [ENERGY_W-1:0]     r_sum;
    logic [HW_W-1:0]         r_inf;
    logic                    r_sat;

    // Output register
    logic                    r_out_vld;
    logic [ENERGY_W-1:0]     r_out_energy;
    logic [INF_W-1:0]        r_out_inf;
    logic                    r_out_ovf;

    logic [1:0]              axis;
    logic                    is_b;
    logic [POS_W-1:0]        pa, pb, pp;
    logic [POS_W:0]          d, d_mag;
    logic                    d_pos, gate;
    logic [POS_W-1:0]        sq_in;
    logic                    k_neg;
    logic [K_W-1:0]          k_abs;
    logic                    u_pos;
    logic [HI_W-1:0]         u_hi;
    logic [LO_W-1:0]         u_lo;
    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic [PROD_W-1:0]       mul_p;
    logic [PROD_W:0]         lo_rnd;
    logic [ENERGY_W:0]       e_ext, e_sgn, s_ext;
    logic                    s_ovf;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_pz   <= i_pos_z;
            r_kind <= i_molecule_kind;
            r_last <= i_last_in_group;
        end
    end

    // Axis and face of the current square term
    always_comb begin
        case (i_cmd.op)
            OP_A0:   begin axis = 2'd0; is_b = 1'b0; end
            OP_A1:   begin axis = 2'd1; is_b = 1'b0; end
            OP_A2:   begin axis = 2'd2; is_b = 1'b0; end
            OP_B0:   begin axis = 2'd0; is_b = 1'b1; end
            OP_B1:   begin axis = 2'd1; is_b = 1'b1; end
            OP_B2:   begin axis = 2'd2; is_b = 1'b1; end
            default: begin axis = 2'd0; is_b = 1'b0; end
        endcase
        case (axis)
            2'd0: begin
                pa = i_cfg.point_a[POS_W-1:0];
                pb = i_cfg.point_b[POS_W-1:0];
                pp = r_px;
            end
            2'd1: begin
                pa = i_cfg.point_a[2*POS_W-1:POS_W];
                pb = i_cfg.point_b[2*POS_W-1:POS_W];
                pp = r_py;
            end
            default: begin
                pa = i_cfg.point_a[3*POS_W-1:2*POS_W];
                pb = i_cfg.point_b[3*POS_W-1:2*POS_W];
                pp = r_pz;
            end
        endcase
    end

    // Signed distance and magnitude; box faces only count when outside
    always_comb begin
        if (is_b) begin
            d = {pp[POS_W-1], pp} - {pb[POS_W-1], pb};
        end else begin
            d = {pa[POS_W-1], pa} - {pp[POS_W-1], pp};
        end
        d_mag = d[POS_W] ? (~d + (POS_W+1)'(1)) : d;
        d_pos = !d[POS_W] && (d != '0);
        gate  = (is_b || (i_cfg.mode == MODE_BOX)) ? d_pos : 1'b1;
        sq_in = gate ? d_mag[POS_W-1:0] : '0;
    end

    // Spring constant magnitude and squared-excess slices
    assign k_neg = i_cfg.wall_k[K_W-1];
    assign k_abs = k_neg ? (~i_cfg.wall_k + K_W'(1)) : i_cfg.wall_k;
    assign u_pos = !r_u[U_W-1] && (r_u != '0);
    assign u_hi  = r_u[LO_W+HI_W-1:LO_W];
    assign u_lo  = r_u[LO_W-1:0];

    // Shared multiplier operand select
    always_comb begin
        case (i_cmd.op)
            OP_R: begin
                mul_a = MUL_A_W'(i_cfg.radius);
                mul_b = MUL_B_W'(i_cfg.radius);
            end
            OP_HI: begin
                mul_a = k_abs;
                mul_b = MUL_B_W'(u_hi);
            end
            OP_LO: begin
                mul_a = k_abs;
                mul_b = MUL_B_W'(u_lo);
            end
            default: begin
                mul_a = MUL_A_W'(sq_in);
                mul_b = MUL_B_W'(sq_in);
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        r_tag  <= i_cmd.op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_vld <= 1'b0;
        end else begin
            r_tag_vld <= i_cmd.op_valid;
        end
    end

    // Squared excess and spring energy accumulate from the product register
    assign lo_rnd = {1'b0, r_prod} + RND_HALF;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_u <= '0;
        end else if (r_tag_vld) begin
            case (r_tag)
                OP_A0, OP_A1, OP_A2, OP_B0, OP_B1, OP_B2: begin
                    r_u <= r_u + $signed(U_W'(r_prod));
                end
                OP_R: begin
                    r_u <= r_u - $signed(U_W'(r_prod));
                end
                OP_HI: begin
                    r_e <= {r_prod, {HI_SHIFT{1'b0}}};
                end
                OP_LO: begin
                    r_e <= r_e + E_W'(lo_rnd[PROD_W:FRAC_SHIFT]);
                end
                default: ;
            endcase
        end
    end

    // Signed particle energy and saturating group add
    always_comb begin
        e_ext = (ENERGY_W+1)'(r_e);
        e_sgn = k_neg ? (~e_ext + (ENERGY_W+1)'(1)) : e_ext;
        s_ext = {r_sum[ENERGY_W-1], r_sum} + e_sgn;
        s_ovf = s_ext[ENERGY_W] ^ s_ext[ENERGY_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_inf <= WALL_FINITE;
            r_sat <= 1'b0;
        end else if (i_cmd.emit) begin
            r_sum <= '0;
            r_inf <= WALL_FINITE;
            r_sat <= 1'b0;
        end else begin
            if (i_cmd.add_e) begin
                if (s_ovf) begin
                    r_sum <= s_ext[ENERGY_W] ? ENERGY_MIN : ENERGY_MAX;
                    r_sat <= 1'b1;
                end else begin
                    r_sum <= s_ext[ENERGY_W-1:0];
                end
            end
            if (i_cmd.set_inf) begin
                r_inf <= i_cfg.hard_wall;
            end
        end
    end

    // Output register: infinite groups report zero energy and no overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_energy <= (r_inf != WALL_FINITE) ? '0 : r_sum;
            r_out_inf    <= r_inf;
            r_out_ovf    <= (r_inf != WALL_FINITE) ? 1'b0 : r_sat;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_group_energy  = r_out_energy;
    assign o_infinite_sign = r_out_inf;
    assign o_overflowed    = r_out_ovf;

    // Status to the sequencer
    always_comb begin
        o_sts.mode     = i_cfg.mode;
        o_sts.sel      = i_cfg.kind_mask[r_kind] && (i_cfg.mode != MODE_NONE);
        o_sts.u_pos    = u_pos;
        o_sts.inf_wall = (i_cfg.hard_wall == WALL_POS_INF) ||
                         (i_cfg.hard_wall == WALL_NEG_INF);
        o_sts.last     = r_last;
        o_sts.out_free = !r_out_vld || i_ready;
    end

    // The infinite mark only ever holds the finite code or one of the two infinite codes
    a_inf_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_inf[0] && r_inf[1]))
        else $error("invalid infinite code in group state");

    // Emitting a result starts the next group from a clean state
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> ((r_sum == '0) && (r_inf == WALL_FINITE) && !r_sat && r_out_vld))
        else $error("group state not cleared after result");

endmodule

FILE: rtl/harmonic_confinement_energy.sv
// ============================================================================
// harmonic_confinement_energy: harmonic wall confinement energy per group
// Particles stream in one per transfer; confined kinds add k/2 times the
// squared excess beyond a sphere, a z-cylinder or a box, and the saturating
// Q48.16 group sum leaves as one result transfer after the last particle.
//
// One particle is processed at a time. A confined particle issues n square
// terms, where n is 4 for the sphere (three axes and the radius), 3 for the
// cylinder and 6 for the box (both faces on every axis), then both halves of
// the spring product, the accumulate and the group add. A particle with no
// excess, or one that meets an infinite wall, skips the spring product; a
// particle whose kind is not confined, or any particle in the unused fourth
// mode, goes straight to the group step. The single shared 32x22 multiplier
// computes every square and both halves of the spring product one per
// cycle, followed by the accumulate and the 64-bit saturating add. Results
// sit in an output register, so input continues while a result waits; a
// group's last particle holds in its final cycle only if the previous result
// has not yet been taken. Configuration is written over APB at byte address
// 8 times the register index and must only change while the block is idle.
// ============================================================================
module harmonic_confinement_energy #(
    parameter int KIND_COUNT = hce_pkg::KIND_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    hce_in_if.sink                     i_in,
    hce_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hce_pkg::APB_AW-1:0] paddr,
    input  logic [hce_pkg::APB_DW-1:0] pwdata,
    output logic [hce_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import hce_pkg::*;

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    // Configuration registers
    hce_regs #(
        .KIND_COUNT (KIND_COUNT)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer
    hce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    assign i_in.ready = in_ready;

    // Datapath and result register
    hce_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_pos_x         (i_in.pos_x),
        .i_pos_y         (i_in.pos_y),
        .i_pos_z         (i_in.pos_z),
        .i_molecule_kind (i_in.molecule_kind),
        .i_last_in_group (i_in.last_in_group),
        .o_valid         (o_out.valid),
        .i_ready         (o_out.ready),
        .o_group_energy  (o_out.group_energy),
        .o_infinite_sign (o_out.infinite_sign),
        .o_overflowed    (o_out.overflowed)
    );

endmodule
